[hw/rtl/bast_pkg.sv]
// Shared types and constants for the bump allocator with span crossing table.
// Depends on nothing; bast_align and the top level import it.
package bast_pkg;

    // Default region geometry, handed to the top level as parameter defaults.
    localparam int REGION_BYTES_DEF = 65536;
    localparam int SPAN_BYTES_DEF   = 1024;
    localparam int HEADER_BYTES_DEF = 1024;
    localparam int OBJECT_ALIGN_DEF = 8;

    // Widths fixed by the word fields.
    localparam int SIZE_W    = 16;
    localparam int SPAN_IN_W = 6;
    localparam int STATUS_W  = 2;

    // Largest span table that a 6-bit span number can reach.
    localparam int SPAN_TABLE_MAX = 64;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_QUERY = 2'd1,
        OP_DIRTY = 2'd2,
        OP_RESET = 2'd3
    } op_t;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOFIT    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MISALIGN = 2'd2;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CHECK = 5'b00010,
        S_WALK  = 5'b00100,
        S_QUERY = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    // Request to and response from the alignment checker.
    typedef struct packed {
        logic              start;
        logic [SIZE_W-1:0] size;
    } align_req_t;

    typedef struct packed {
        logic done;
        logic aligned;
    } align_rsp_t;

endpackage

[hw/rtl/bast_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module bast_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/bast_align.sv]
// Two-stage check that a size is a multiple of the object alignment.
// Depends on bast_pkg; a reciprocal multiply gives the quotient, a second
// multiply checks it back against the size.
module bast_align #(
    parameter int OBJECT_ALIGN = bast_pkg::OBJECT_ALIGN_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  bast_pkg::align_req_t   req,
    output bast_pkg::align_rsp_t   rsp
);
    import bast_pkg::*;

    // With a 22-bit shift the rounded-up reciprocal is exact for 16-bit sizes
    // and any alignment up to 64.
    localparam int RSHIFT = 22;
    localparam int RW     = RSHIFT + 1;
    localparam int PW     = SIZE_W + RW;
    localparam logic [RW-1:0] RECIP = RW'((2 ** RSHIFT + OBJECT_ALIGN - 1) / OBJECT_ALIGN);
    localparam logic [6:0]    ALIGN_C = 7'(OBJECT_ALIGN);

    logic              stage1_reg;
    logic              done_reg;
    logic              aligned_reg;
    logic [SIZE_W-1:0] quot_reg;
    logic [SIZE_W-1:0] size_reg;

    logic [PW-1:0]     prod1;
    logic [RW-1:0]     prod2;

    assign prod1 = PW'(req.size) * PW'(RECIP);
    assign prod2 = RW'(quot_reg) * RW'(ALIGN_C);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage1_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            stage1_reg <= req.start;
            done_reg   <= stage1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quot_reg <= prod1[RSHIFT+SIZE_W-1:RSHIFT];
            size_reg <= req.size;
        end
        if (stage1_reg)
        begin
            aligned_reg <= (prod2 == RW'(size_reg));
        end
    end

    assign rsp.done    = done_reg;
    assign rsp.aligned = aligned_reg;

endmodule

[hw/rtl/bump_allocator_span_table_top.sv]
// Top level of the bump allocator with its span crossing table.
// Depends on bast_pkg, bast_align and bast_ram.
//
//   Channel | Direction | Handshake          | Word fields
//   --------+-----------+--------------------+------------------------------------------
//   in      | to block  | in_valid, in_stall | operation, alloc_bytes, span_number,
//           |           |                    | dirty_value
//   out     | from block| out_valid,out_stall| status, obj_offset, remaining_bytes,
//           |           |                    | span_has_object, span_last_offset, span_dirty
//
// An allocate word walks the spans from the object's first span to the span holding its end
// address, marking each span in the table, once the alignment and fit checks have passed.
// The walk over those spans is set by the single write port of the span table, one span
// per cycle. A rejected allocate skips the walk. A query reads the table through its
// registered read port; a dirty update or region reset is done in the idle state.
// Reset clears the bump pointer and all valid and dirty bits at once; there is no clearing pass.
// The result sits in an output register, so a new word is accepted while out_stall holds a
// finished result; a second result waits inside until the register frees up.
module bump_allocator_span_table_top #(
    parameter int REGION_BYTES = bast_pkg::REGION_BYTES_DEF,
    parameter int SPAN_BYTES   = bast_pkg::SPAN_BYTES_DEF,
    parameter int HEADER_BYTES = bast_pkg::HEADER_BYTES_DEF,
    parameter int OBJECT_ALIGN = bast_pkg::OBJECT_ALIGN_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        operation,
    input  logic [bast_pkg::SIZE_W-1:0]       alloc_bytes,
    input  logic [bast_pkg::SPAN_IN_W-1:0]    span_number,
    input  logic                              dirty_value,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [bast_pkg::STATUS_W-1:0]     status,
    output logic [bast_pkg::SIZE_W-1:0]       obj_offset,
    output logic [bast_pkg::SIZE_W-1:0]       remaining_bytes,
    output logic                              span_has_object,
    output logic [bast_pkg::SIZE_W-1:0]       span_last_offset,
    output logic                              span_dirty
);
    import bast_pkg::*;

    // Region geometry. The table only holds the spans a 6-bit span number can name;
    // spans past it are walked over for the cursor but never stored.
    localparam int USABLE_BYTES = (REGION_BYTES > HEADER_BYTES) ? REGION_BYTES - HEADER_BYTES : 0;
    localparam int SPAN_COUNT   = REGION_BYTES / SPAN_BYTES;
    localparam int VALID_SPANS  = (SPAN_COUNT < SPAN_TABLE_MAX) ? SPAN_COUNT : SPAN_TABLE_MAX;
    localparam int TABLE_DEPTH  = (VALID_SPANS > 0) ? VALID_SPANS : 1;
    localparam int TIDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int ADDR_W       = $clog2(REGION_BYTES + HEADER_BYTES + SPAN_BYTES + 65536 + 1);
    localparam int USED_W       = (USABLE_BYTES > 0) ? $clog2(USABLE_BYTES + 1) : 1;

    localparam logic [ADDR_W-1:0] USABLE_A = ADDR_W'(USABLE_BYTES);
    localparam logic [ADDR_W-1:0] HEADER_A = ADDR_W'(HEADER_BYTES);
    localparam logic [ADDR_W-1:0] SPAN_A   = ADDR_W'(SPAN_BYTES);
    localparam logic [ADDR_W-1:0] VALID_A  = ADDR_W'(VALID_SPANS);
    // Span holding the first buffer byte, and the address where that span ends.
    localparam logic [ADDR_W-1:0] CUR0_A   = ADDR_W'(HEADER_BYTES / SPAN_BYTES);
    localparam logic [ADDR_W-1:0] LIM0_A   = ADDR_W'((HEADER_BYTES / SPAN_BYTES + 1) * SPAN_BYTES);

    // Control state.
    state_t                  state_reg, state_next;
    logic [USED_W-1:0]       used_reg, used_next;
    logic [ADDR_W-1:0]       cursor_reg, cursor_next;
    logic [ADDR_W-1:0]       limit_reg, limit_next;
    logic [TABLE_DEPTH-1:0]  span_valid_reg, span_valid_next;
    logic [TABLE_DEPTH-1:0]  span_dirty_reg, span_dirty_next;
    logic                    out_valid_reg, out_valid_next;

    // Word being worked on and its pending result.
    logic [SIZE_W-1:0]       size_reg, size_next;
    logic [SPAN_IN_W-1:0]    span_reg, span_next;
    logic [ADDR_W-1:0]       end_reg, end_next;
    logic [STATUS_W-1:0]     res_status_reg, res_status_next;
    logic [SIZE_W-1:0]       res_offset_reg, res_offset_next;
    logic                    res_has_reg, res_has_next;
    logic [SIZE_W-1:0]       res_last_reg, res_last_next;
    logic                    res_dirty_reg, res_dirty_next;

    // Output word register.
    logic [STATUS_W-1:0]     status_reg;
    logic [SIZE_W-1:0]       offset_reg;
    logic [SIZE_W-1:0]       remain_reg;
    logic                    has_reg;
    logic [SIZE_W-1:0]       last_reg;
    logic                    dirty_reg;
    logic                    out_load;

    logic                    in_accept;
    op_t                     op_in;
    logic                    span_in_range;
    logic [TIDX_W-1:0]       span_idx_in;
    logic                    query_in_range;
    logic [TIDX_W-1:0]       query_idx;
    logic                    cursor_in_table;
    logic [TIDX_W-1:0]       cursor_idx;
    logic [ADDR_W-1:0]       used_ext;
    logic [ADDR_W-1:0]       size_ext;
    logic [ADDR_W-1:0]       remaining_a;

    align_req_t              align_req;
    align_rsp_t              align_rsp;
    logic                    ram_we;
    logic [SIZE_W-1:0]       ram_rdata;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign op_in     = op_t'(operation);

    assign span_in_range  = (ADDR_W'(span_number) < VALID_A);
    assign span_idx_in    = span_number[TIDX_W-1:0];
    assign query_in_range = (ADDR_W'(span_reg) < VALID_A);
    assign query_idx      = span_reg[TIDX_W-1:0];
    assign cursor_in_table = (cursor_reg < VALID_A);
    assign cursor_idx      = cursor_reg[TIDX_W-1:0];

    assign used_ext    = ADDR_W'(used_reg);
    assign size_ext    = ADDR_W'(size_reg);
    assign remaining_a = USABLE_A - used_ext;

    assign align_req.start = in_accept && (op_in == OP_ALLOC);
    assign align_req.size  = alloc_bytes;

    assign ram_we   = (state_reg == S_WALK) && cursor_in_table;
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);

    bast_align #(
        .OBJECT_ALIGN (OBJECT_ALIGN)
    ) u_align (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (align_req),
        .rsp   (align_rsp)
    );

    // Last allocation offset per span; validity lives in span_valid_reg.
    bast_ram #(
        .WIDTH (SIZE_W),
        .DEPTH (TABLE_DEPTH),
        .AW    (TIDX_W)
    ) u_span_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cursor_idx),
        .wdata (res_offset_reg),
        .re    (in_accept),
        .raddr (span_idx_in),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next      = state_reg;
        used_next       = used_reg;
        cursor_next     = cursor_reg;
        limit_next      = limit_reg;
        span_valid_next = span_valid_reg;
        span_dirty_next = span_dirty_reg;
        size_next       = size_reg;
        span_next       = span_reg;
        end_next        = end_reg;
        res_status_next = res_status_reg;
        res_offset_next = res_offset_reg;
        res_has_next    = res_has_reg;
        res_last_next   = res_last_reg;
        res_dirty_next  = res_dirty_reg;
        out_valid_next  = out_valid_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    size_next       = alloc_bytes;
                    span_next       = span_number;
                    res_status_next = ST_OK;
                    res_offset_next = '0;
                    res_has_next    = 1'b0;
                    res_last_next   = '0;
                    res_dirty_next  = 1'b0;
                    case (op_in)
                        OP_ALLOC:
                        begin
                            state_next = S_CHECK;
                        end
                        OP_QUERY:
                        begin
                            state_next = S_QUERY;
                        end
                        OP_DIRTY:
                        begin
                            if (span_in_range)
                            begin
                                span_dirty_next[span_idx_in] = dirty_value;
                            end
                            state_next = S_DONE;
                        end
                        default:
                        begin
                            // Region reset clears the bump pointer, cursor and all valid and dirty bits at once.
                            used_next       = '0;
                            cursor_next     = CUR0_A;
                            limit_next      = LIM0_A;
                            span_valid_next = '0;
                            span_dirty_next = '0;
                            state_next      = S_DONE;
                        end
                    endcase
                end
            end

            S_CHECK:
            begin
                if (align_rsp.done)
                begin
                    if (!align_rsp.aligned)
                    begin
                        res_status_next = ST_MISALIGN;
                        state_next      = S_DONE;
                    end
                    else if (size_ext > remaining_a)
                    begin
                        res_status_next = ST_NOFIT;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        res_offset_next = used_ext[SIZE_W-1:0];
                        end_next        = HEADER_A + used_ext + size_ext;
                        used_next       = USED_W'(used_ext + size_ext);
                        state_next      = S_WALK;
                    end
                end
            end

            S_WALK:
            begin
                // Mark the span under the cursor, then step on while the object's
                // end address lies at or past the end of that span.
                if (cursor_in_table)
                begin
                    span_valid_next[cursor_idx] = 1'b1;
                end
                if (end_reg >= limit_reg)
                begin
                    cursor_next = cursor_reg + ADDR_W'(1);
                    limit_next  = limit_reg + SPAN_A;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_QUERY:
            begin
                if (query_in_range)
                begin
                    res_has_next   = span_valid_reg[query_idx];
                    res_last_next  = span_valid_reg[query_idx] ? ram_rdata : '0;
                    res_dirty_next = span_dirty_reg[query_idx];
                end
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            used_reg       <= '0;
            cursor_reg     <= CUR0_A;
            limit_reg      <= LIM0_A;
            span_valid_reg <= '0;
            span_dirty_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            used_reg       <= used_next;
            cursor_reg     <= cursor_next;
            limit_reg      <= limit_next;
            span_valid_reg <= span_valid_next;
            span_dirty_reg <= span_dirty_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        size_reg       <= size_next;
        span_reg       <= span_next;
        end_reg        <= end_next;
        res_status_reg <= res_status_next;
        res_offset_reg <= res_offset_next;
        res_has_reg    <= res_has_next;
        res_last_reg   <= res_last_next;
        res_dirty_reg  <= res_dirty_next;
        if (out_load)
        begin
            status_reg <= res_status_reg;
            offset_reg <= res_offset_reg;
            remain_reg <= remaining_a[SIZE_W-1:0];
            has_reg    <= res_has_reg;
            last_reg   <= res_last_reg;
            dirty_reg  <= res_dirty_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign status           = status_reg;
    assign obj_offset       = offset_reg;
    assign remaining_bytes  = remain_reg;
    assign span_has_object  = has_reg;
    assign span_last_offset = last_reg;
    assign span_dirty       = dirty_reg;

`ifndef ASSERT_OFF
    // An accepted allocate word always goes to the alignment check next.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && op_in == OP_ALLOC) |=> (state_reg == S_CHECK))
        else $error("allocate word did not enter the check state");

    // The alignment checker only answers while the sequencer waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        align_rsp.done |-> (state_reg == S_CHECK))
        else $error("alignment result arrived outside the check state");

    // When a walk ends, the cursor span contains the object's end address.
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(state_reg == S_WALK) |-> (limit_reg > end_reg))
        else $error("span walk stopped before the end span");

    // A dirty update within the table lands in the addressed bit.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && op_in == OP_DIRTY && span_in_range)
        |=> (span_dirty_reg[$past(span_idx_in)] == $past(dirty_value)))
        else $error("dirty bit not written");
`endif

endmodule
